[sv/klp_pkg.sv]
package klp_pkg;

    // Byte codes seen on the serial link
    localparam logic [7:0] ACK_BYTE   = 8'h06;
    localparam logic [7:0] CR_BYTE    = 8'h0D;
    localparam logic [7:0] CAT_FUNC   = 8'h46;
    localparam logic [7:0] CAT_ROUTE  = 8'h4B;
    localparam logic [7:0] DIGIT_ZERO = 8'h30;
    localparam logic [7:0] DIGIT_NINE = 8'h39;

    // Saturation limit of the decimal number
    localparam logic [15:0] NUM_MAX = 16'hFFFF;

    // Line kinds reported in a result
    localparam logic [1:0] KIND_UNEXPECTED = 2'd0;
    localparam logic [1:0] KIND_FUNCTION   = 2'd1;
    localparam logic [1:0] KIND_ROUTE      = 2'd2;
    localparam logic [1:0] KIND_OVERLONG   = 2'd3;

    // Register index of the configuration port
    localparam logic REG_CELL_COUNT = 1'b0;

    // Function-key numbers in command-code order
    localparam int FKEY_COUNT = 12;
    localparam logic [5:0] FKEY_TABLE [FKEY_COUNT] = '{
        6'd1, 6'd2, 6'd3, 6'd4, 6'd5, 6'd6, 6'd23, 6'd56, 6'd14, 6'd25, 6'd26, 6'd36
    };

    // One parsed result
    typedef struct packed {
        logic [1:0] kind;
        logic [3:0] code;
        logic [7:0] route;
        logic       ack;
    } result_t;

    // Outcome of a function-key table search
    typedef struct packed {
        logic       hit;
        logic [3:0] code;
    } fkey_hit_t;

    // Search the function-key table; the entries are distinct, so at most one matches.
    function automatic fkey_hit_t fkey_lookup(input logic [15:0] number);
        fkey_hit_t found;
        found = '0;
        for (int i = 0; i < FKEY_COUNT; i++)
        begin
            if (number == {10'd0, FKEY_TABLE[i]})
            begin
                found.hit  = 1'b1;
                found.code = 4'(i);
            end
        end
        return found;
    endfunction

endpackage

[sv/klp_parser.sv]
module klp_parser #(
    parameter int LINE_BYTES = 256
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 step_valid,
    input  logic [7:0]           step_byte,
    input  logic [7:0]           cell_count,
    output logic                 result_valid,
    output klp_pkg::result_t     result
);

    localparam int POS_W = $clog2(LINE_BYTES);

    logic [POS_W-1:0] pos_reg, pos_next;
    logic [7:0]       category_reg, category_next;
    logic [15:0]      number_reg, number_next;
    logic             digit_seen_reg, digit_seen_next;
    logic             junk_seen_reg, junk_seen_next;

    logic                line_open;
    logic                is_ack;
    logic                is_cr;
    logic                is_digit;
    logic [3:0]          digit_val;
    logic [19:0]         product;
    logic [15:0]         number_sat;
    logic                last_slot;
    logic                number_ok;
    klp_pkg::fkey_hit_t  fkey;
    klp_pkg::result_t    finish;

    // Byte classification
    assign line_open = (pos_reg != '0);
    assign is_ack    = !line_open && (step_byte == klp_pkg::ACK_BYTE);
    assign is_cr     = (step_byte == klp_pkg::CR_BYTE);
    assign is_digit  = (step_byte >= klp_pkg::DIGIT_ZERO) && (step_byte <= klp_pkg::DIGIT_NINE);
    assign digit_val = 4'(step_byte - klp_pkg::DIGIT_ZERO);
    assign last_slot = (pos_reg == POS_W'(LINE_BYTES - 1));

    // Running decimal value: n*10 + d, saturating at 16 bits
    assign product    = ({4'd0, number_reg} << 3) + ({4'd0, number_reg} << 1) + {16'd0, digit_val};
    assign number_sat = (product > {4'd0, klp_pkg::NUM_MAX}) ? klp_pkg::NUM_MAX : product[15:0];

    // Decode of a completed line
    assign number_ok = line_open && digit_seen_reg && !junk_seen_reg;
    assign fkey      = klp_pkg::fkey_lookup(number_reg);

    always_comb
    begin
        finish = '0;
        finish.kind = klp_pkg::KIND_UNEXPECTED;
        if (line_open && category_reg == klp_pkg::CAT_FUNC)
        begin
            finish.ack = 1'b1;
            if (number_ok && fkey.hit)
            begin
                finish.kind = klp_pkg::KIND_FUNCTION;
                finish.code = fkey.code;
            end
        end
        else if (line_open && category_reg == klp_pkg::CAT_ROUTE)
        begin
            finish.ack = 1'b1;
            if (number_ok && number_reg != 16'd0 && number_reg <= {8'd0, cell_count})
            begin
                finish.kind  = klp_pkg::KIND_ROUTE;
                finish.route = 8'(number_reg - 16'd1);
            end
        end
    end

    // Line state update for one byte
    always_comb
    begin
        pos_next        = pos_reg;
        category_next   = category_reg;
        number_next     = number_reg;
        digit_seen_next = digit_seen_reg;
        junk_seen_next  = junk_seen_reg;
        result_valid    = 1'b0;
        result          = '0;
        if (step_valid && !is_ack)
        begin
            if (is_cr)
            begin
                result_valid    = 1'b1;
                result          = finish;
                pos_next        = '0;
                category_next   = '0;
                number_next     = '0;
                digit_seen_next = 1'b0;
                junk_seen_next  = 1'b0;
            end
            else
            begin
                if (!line_open)
                begin
                    category_next = step_byte;
                end
                else if (!junk_seen_reg && is_digit)
                begin
                    number_next     = number_sat;
                    digit_seen_next = 1'b1;
                end
                else
                begin
                    junk_seen_next = 1'b1;
                end

                if (last_slot)
                begin
                    // Line buffer full with no terminator: report and discard.
                    result_valid    = 1'b1;
                    result.kind     = klp_pkg::KIND_OVERLONG;
                    pos_next        = '0;
                    category_next   = '0;
                    number_next     = '0;
                    digit_seen_next = 1'b0;
                    junk_seen_next  = 1'b0;
                end
                else
                begin
                    pos_next = pos_reg + POS_W'(1);
                end
            end
        end
    end

    // Line state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg        <= '0;
            category_reg   <= '0;
            number_reg     <= '0;
            digit_seen_reg <= 1'b0;
            junk_seen_reg  <= 1'b0;
        end
        else
        begin
            pos_reg        <= pos_next;
            category_reg   <= category_next;
            number_reg     <= number_next;
            digit_seen_reg <= digit_seen_next;
            junk_seen_reg  <= junk_seen_next;
        end
    end

endmodule

[sv/key_report_line_parser_unit.sv]
// Channel   Direction  Handshake            Payload
// input     in         in_valid / in_stall  rx_byte
// output    out        out_valid/ out_stall line_kind, command_code, route_cell, send_ack
// config    in         APB write/read       cell_count at byte address 0
//
// One byte is accepted per cycle while in_stall is low; the result of a byte ending its line
// passes from the input register through the parser into the result register, or into the
// skid entry while the result register is held.
// Reset is asynchronous and active low; it clears the line state and sets cell_count to 40.
// Results queue in the result register and one skid entry; in_stall rises only when
// a byte waits in the input register while both entries are full.
module key_report_line_parser_unit #(
    parameter int LINE_BYTES = 256
) (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  rx_byte,

    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  line_kind,
    output logic [3:0]  command_code,
    output logic [7:0]  route_cell,
    output logic        send_ack,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [7:0]       cell_count_reg;
    logic             in_valid_reg;
    logic [7:0]       in_byte_reg;
    logic             out_valid_reg;
    klp_pkg::result_t out_data_reg;
    logic             skid_valid_reg;
    klp_pkg::result_t skid_data_reg;

    logic             advance;
    logic             pop;
    logic             res_valid;
    klp_pkg::result_t res_data;

    // Configuration register
    assign pready = 1'b1;
    assign prdata = (paddr[2] == klp_pkg::REG_CELL_COUNT) ? {24'd0, cell_count_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cell_count_reg <= 8'd40;
        end
        else if (psel && penable && pwrite && paddr[2] == klp_pkg::REG_CELL_COUNT)
        begin
            cell_count_reg <= pwdata[7:0];
        end
    end

    // Input register: the held byte moves on whenever the skid entry is free.
    assign advance  = in_valid_reg && !skid_valid_reg;
    assign in_stall = in_valid_reg && skid_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
        begin
            in_byte_reg <= rx_byte;
        end
    end

    klp_parser #(
        .LINE_BYTES(LINE_BYTES)
    ) u_parser (
        .clk          (clk),
        .rst_n        (rst_n),
        .step_valid   (advance),
        .step_byte    (in_byte_reg),
        .cell_count   (cell_count_reg),
        .result_valid (res_valid),
        .result       (res_data)
    );

    // Result register with one skid entry behind it
    assign pop = out_valid_reg && !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (!out_valid_reg || pop)
            begin
                out_valid_reg  <= skid_valid_reg || res_valid;
                skid_valid_reg <= 1'b0;
            end
            else if (res_valid)
            begin
                skid_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || pop)
        begin
            out_data_reg <= skid_valid_reg ? skid_data_reg : res_data;
        end
        else if (res_valid)
        begin
            skid_data_reg <= res_data;
        end
    end

    assign out_valid    = out_valid_reg;
    assign line_kind    = out_data_reg.kind;
    assign command_code = out_data_reg.code;
    assign route_cell   = out_data_reg.route;
    assign send_ack     = out_data_reg.ack;

    // The skid entry is only ever filled behind a held result.
    a_skid_behind_head: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry valid while result register empty");

    // A byte blocked by a full queue is still held in the next cycle.
    a_blocked_byte_held: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && skid_valid_reg) |=> in_valid_reg)
        else $error("blocked input byte was lost");

    // An overlong line carries no command, cell or acknowledge.
    a_overlong_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && line_kind == klp_pkg::KIND_OVERLONG)
            |-> (!send_ack && command_code == 4'd0 && route_cell == 8'd0))
        else $error("overlong result with nonzero fields");

    // A command code appears only on a function-command result.
    a_code_only_function: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && line_kind != klp_pkg::KIND_FUNCTION) |-> (command_code == 4'd0))
        else $error("command code on a non-function result");

    // A routing result always requests an acknowledge.
    a_route_acks: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && line_kind == klp_pkg::KIND_ROUTE) |-> send_ack)
        else $error("routing result without acknowledge");

endmodule
